// ----- design/ast_pkg.sv -----
// Types, command codes and reply constants for the accessory status table.
// No dependencies; imported by accessory_status_table_top.
`timescale 1ns / 1ps
`default_nettype none

package ast_pkg;

   // Command codes
   localparam logic [1:0] CMD_FEEDBACK_WRITE = 2'd0;
   localparam logic [1:0] CMD_COIL_WRITE     = 2'd1;
   localparam logic [1:0] CMD_POSITION_READ  = 2'd2;
   localparam logic [1:0] CMD_INFO_READ      = 2'd3;

   // ITTNZZZZ reply fields
   localparam logic [7:0] TT_FEEDBACK_TURNOUT    = 8'b0010_0000;
   localparam logic [7:0] TT_FEEDBACK_TURNOUT_HI = 8'b0011_0000;
   localparam logic [7:0] TT_FEEDBACK_DECODER    = 8'b0100_0000;
   localparam logic [7:0] TT_FEEDBACK_DECODER_HI = 8'b0101_0000;
   localparam logic [7:0] N_BIT                  = 8'b0001_0000;
   localparam logic [7:0] I_BIT                  = 8'h80;

   // Stored turnout codes
   localparam logic [1:0] POS_COIL0 = 2'b01;
   localparam logic [1:0] POS_COIL1 = 2'b10;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] decoder_address;
      logic       half_select;
      logic [9:0] turnout_address;
      logic       coil;
      logic [7:0] feedback_data;
   } ast_req_type;

   typedef struct packed {
      logic [7:0] old_byte;
      logic [1:0] position;
      logic [7:0] reply_address;
      logic [7:0] reply_info;
      logic       out_of_range;
   } ast_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } ast_state_type;

   // Extract one 2-bit turnout field from a decoder byte
   function automatic logic [1:0] get_pair(input logic [7:0] b, input logic [1:0] sel);
      logic [1:0] r;
      case (sel)
         2'd0:    r = b[1:0];
         2'd1:    r = b[3:2];
         2'd2:    r = b[5:4];
         default: r = b[7:6];
      endcase
      return r;
   endfunction

   // Replace one 2-bit turnout field in a decoder byte
   function automatic logic [7:0] set_pair(input logic [7:0] b, input logic [1:0] sel,
                                           input logic [1:0] v);
      logic [7:0] r;
      r = b;
      case (sel)
         2'd0:    r[1:0] = v;
         2'd1:    r[3:2] = v;
         2'd2:    r[5:4] = v;
         default: r[7:6] = v;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- design/accessory_status_table_top.sv -----
// Accessory status table: decoder byte store, turnout feedback store and
// feedback decoder marks with a two-step read-modify-write sequencer.
// Depends on ast_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One request is taken at a time: the accepting edge issues the reads of
// the accessory memory, the feedback memory and the mark bits, and the
// execute state then writes back and loads the response register. A new
// request is taken in the cycle after that; no request is accepted while
// one is still in the execute state, and a stalled response holds the
// sequencer in the execute state until the previous response is taken. All
// stores read as zero after reset: per-entry valid bits, cleared at once by
// reset, stand in for the stored bytes until an entry is written, so no
// clearing pass is needed. Writes to addresses beyond the stores are dropped
// and flagged with out_of_range; reads beyond the stores return zero.
module accessory_status_table_top
   import ast_pkg::*;
#(
   parameter int ACCESSORY_ADDRESSES = 32,
   parameter int FEEDBACK_TURNOUTS   = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire ast_req_type req_data,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output ast_rsp_type rsp_data
);

   localparam int ACC_AW      = $clog2(ACCESSORY_ADDRESSES);
   localparam int FB_BYTES    = (FEEDBACK_TURNOUTS + 3) / 4;
   localparam int FB_DEPTH    = (FB_BYTES > 0) ? FB_BYTES : 1;
   localparam int FB_AW       = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;
   localparam int FB_WR_LIMIT = FEEDBACK_TURNOUTS / 4;

   // ---------------------------------------------------------------------
   // Sequencer state and captured request
   // ---------------------------------------------------------------------
   ast_state_type state_ff, state_in;
   ast_req_type   req_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   ast_rsp_type   rsp_ff, rsp_in;

   logic req_take;
   logic exec_done;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign exec_done = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   // ---------------------------------------------------------------------
   // Read address selection at accept time
   // ---------------------------------------------------------------------
   logic [7:0]        acc_addr;
   logic              acc_addr_ok;
   logic              fb_addr_ok;
   logic [ACC_AW-1:0] acc_ridx;
   logic [FB_AW-1:0]  fb_ridx;

   always_comb begin
      // coil write and position read address by turnout, the rest by decoder
      case (req_data.cmd)
         CMD_COIL_WRITE, CMD_POSITION_READ: acc_addr = req_data.turnout_address[9:2];
         default:                           acc_addr = req_data.decoder_address;
      endcase
   end

   assign acc_addr_ok = {1'b0, acc_addr} < 9'(ACCESSORY_ADDRESSES);
   assign fb_addr_ok  = {1'b0, req_data.decoder_address} < 9'(FB_BYTES);
   assign acc_ridx    = acc_addr[ACC_AW-1:0];
   assign fb_ridx     = req_data.decoder_address[FB_AW-1:0];

   // ---------------------------------------------------------------------
   // Stores
   // ---------------------------------------------------------------------
   logic [7:0]                     acc_mem_ff [ACCESSORY_ADDRESSES];
   logic [ACCESSORY_ADDRESSES-1:0] acc_vld_ff, acc_vld_in;
   logic [7:0]                     fb_mem_ff [FB_DEPTH];
   logic [FB_DEPTH-1:0]            fb_vld_ff, fb_vld_in;
   logic [ACCESSORY_ADDRESSES-1:0] mark_ff, mark_in;

   logic [7:0] acc_rd_ff;
   logic       acc_rd_vld_ff;
   logic [7:0] fb_rd_ff;
   logic       fb_rd_vld_ff;
   logic       mark_rd_ff;

   logic              acc_we, fb_we;
   logic [ACC_AW-1:0] acc_widx;
   logic [FB_AW-1:0]  fb_widx;
   logic [7:0]        acc_wdata, fb_wdata;

   // Accessory memory: registered read on accept, write back on completion
   always_ff @(posedge clock) begin
      if (req_take && acc_addr_ok) begin
         acc_rd_ff <= acc_mem_ff[acc_ridx];
      end
      if (acc_we) begin
         acc_mem_ff[acc_widx] <= acc_wdata;
      end
   end

   // Turnout feedback memory
   always_ff @(posedge clock) begin
      if (req_take && fb_addr_ok) begin
         fb_rd_ff <= fb_mem_ff[fb_ridx];
      end
      if (fb_we) begin
         fb_mem_ff[fb_widx] <= fb_wdata;
      end
   end

   // Valid and mark bits; an entry that was never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff    <= '0;
         fb_vld_ff     <= '0;
         mark_ff       <= '0;
         acc_rd_vld_ff <= 1'b0;
         fb_rd_vld_ff  <= 1'b0;
         mark_rd_ff    <= 1'b0;
      end else begin
         acc_vld_ff <= acc_vld_in;
         fb_vld_ff  <= fb_vld_in;
         mark_ff    <= mark_in;
         if (req_take) begin
            acc_rd_vld_ff <= acc_addr_ok && acc_vld_ff[acc_ridx];
            fb_rd_vld_ff  <= fb_addr_ok && fb_vld_ff[fb_ridx];
            mark_rd_ff    <= acc_addr_ok && mark_ff[acc_ridx];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Execute step: modify, write back, build the response
   // ---------------------------------------------------------------------
   logic [7:0] acc_byte, fb_byte;
   logic       dec_ok, turn_ok, fb_wr_sel;
   logic [9:0] info_base;
   logic [1:0] c0, c1, f0, f1;
   logic       f0_ok, f1_ok, turnout_fb, marked;

   always_comb begin
      acc_byte   = acc_rd_vld_ff ? acc_rd_ff : 8'h00;
      fb_byte    = fb_rd_vld_ff ? fb_rd_ff : 8'h00;
      dec_ok     = {1'b0, req_ff.decoder_address} < 9'(ACCESSORY_ADDRESSES);
      turn_ok    = {1'b0, req_ff.turnout_address[9:2]} < 9'(ACCESSORY_ADDRESSES);
      fb_wr_sel  = {1'b0, req_ff.decoder_address} < 9'(FB_WR_LIMIT);
      info_base  = {req_ff.decoder_address, req_ff.half_select, 1'b0};
      c0         = get_pair(acc_byte, {req_ff.half_select, 1'b0});
      c1         = get_pair(acc_byte, {req_ff.half_select, 1'b1});
      f0_ok      = {1'b0, info_base} < 11'(FEEDBACK_TURNOUTS);
      f1_ok      = {1'b0, info_base[9:1], 1'b1} < 11'(FEEDBACK_TURNOUTS);
      f0         = f0_ok ? get_pair(fb_byte, {req_ff.half_select, 1'b0}) : 2'b00;
      f1         = f1_ok ? get_pair(fb_byte, {req_ff.half_select, 1'b1}) : 2'b00;
      turnout_fb = f0_ok;
      marked     = dec_ok && mark_rd_ff;

      acc_we     = 1'b0;
      fb_we      = 1'b0;
      acc_widx   = req_ff.decoder_address[ACC_AW-1:0];
      fb_widx    = req_ff.decoder_address[FB_AW-1:0];
      acc_wdata  = req_ff.feedback_data;
      fb_wdata   = req_ff.feedback_data;
      acc_vld_in = acc_vld_ff;
      fb_vld_in  = fb_vld_ff;
      mark_in    = mark_ff;
      rsp_in     = '0;

      case (req_ff.cmd)
         CMD_FEEDBACK_WRITE: begin
            if (dec_ok) begin
               mark_in[acc_widx] = exec_done ? 1'b1 : mark_ff[acc_widx];
               if (fb_wr_sel) begin
                  fb_we           = exec_done;
                  rsp_in.old_byte = fb_byte;
               end else begin
                  acc_we          = exec_done;
                  rsp_in.old_byte = acc_byte;
               end
            end else begin
               rsp_in.out_of_range = 1'b1;
            end
         end
         CMD_COIL_WRITE: begin
            acc_widx  = req_ff.turnout_address[ACC_AW+1:2];
            acc_wdata = set_pair(acc_byte, req_ff.turnout_address[1:0],
                                 req_ff.coil ? POS_COIL1 : POS_COIL0);
            if (turn_ok) begin
               acc_we = exec_done;
            end else begin
               rsp_in.out_of_range = 1'b1;
            end
         end
         CMD_POSITION_READ: begin
            rsp_in.position = get_pair(acc_byte, req_ff.turnout_address[1:0]);
         end
         default: begin
            rsp_in.reply_address = req_ff.decoder_address;
            if (turnout_fb) begin
               rsp_in.reply_info = (req_ff.half_select ? TT_FEEDBACK_TURNOUT_HI
                                                       : TT_FEEDBACK_TURNOUT)
                                   | {4'b0000, f1, f0};
               if ((c0 != f0) || (c1 != f1)) begin
                  rsp_in.reply_info = rsp_in.reply_info | I_BIT;
               end
            end else if (marked) begin
               rsp_in.reply_info = req_ff.half_select
                                   ? (TT_FEEDBACK_DECODER_HI | {4'b0000, acc_byte[7:4]})
                                   : (TT_FEEDBACK_DECODER | {4'b0000, acc_byte[3:0]});
            end else begin
               rsp_in.reply_info = (req_ff.half_select ? N_BIT : 8'h00)
                                   | {4'b0000, c1, c0};
            end
         end
      endcase

      if (acc_we) begin
         acc_vld_in[acc_widx] = 1'b1;
      end
      if (fb_we) begin
         fb_vld_in[fb_widx] = 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer and response register
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold until the response slot is free
            if (exec_done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (exec_done) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- tb/accessory_status_table_top_tb.sv -----
// Self-checking testbench for the accessory status table: a directed opening
// sequence, then four random phases under varied request and response pressure.
// Depends on ast_pkg and accessory_status_table_top; uses no other files.
`timescale 1ns / 1ps

module accessory_status_table_top_tb
   import ast_pkg::*;
();

   // Store sizes used by this build of the table
   localparam int ACC_ADDRS       = 32;
   localparam int FB_TURNOUTS     = 16;
   localparam int FB_BYTES        = (FB_TURNOUTS + 3) / 4;
   localparam int PHASE_REQUESTS  = 463;
   localparam int CYCLE_LIMIT     = 400000;

   // Shadow copy of the three stores; predicts one response per request and
   // keeps the responses still owed by the block, oldest first.
   class status_table_scoreboard;
      logic [7:0]  decoder_bytes [ACC_ADDRS];
      logic [7:0]  reported_bytes [FB_BYTES];
      bit          decoder_marks [ACC_ADDRS];
      ast_rsp_type owed_responses [$];
      int          errors;
      int          checked;
      int          flagged;
      int          cmd_seen [4];

      function new();
         foreach (decoder_bytes[i]) decoder_bytes[i] = '0;
         foreach (reported_bytes[i]) reported_bytes[i] = '0;
         foreach (decoder_marks[i]) decoder_marks[i] = 1'b0;
         foreach (cmd_seen[i]) cmd_seen[i] = 0;
         errors  = 0;
         checked = 0;
         flagged = 0;
      endfunction

      function int pending();
         return owed_responses.size();
      endfunction

      // Commanded position of one turnout; zero beyond the decoder store
      function logic [1:0] commanded_pos(input logic [9:0] turnout);
         logic [7:0] b;
         int         sh;
         if (turnout[9:2] >= ACC_ADDRS) return 2'b00;
         b  = decoder_bytes[turnout[9:2]];
         sh = 2 * turnout[1:0];
         return b[sh +: 2];
      endfunction

      // Reported position of one turnout; zero for turnouts without feedback
      function logic [1:0] reported_pos(input logic [9:0] turnout);
         logic [7:0] b;
         int         sh;
         if (turnout >= FB_TURNOUTS || turnout[9:2] >= FB_BYTES) return 2'b00;
         b  = reported_bytes[turnout[9:2]];
         sh = 2 * turnout[1:0];
         return b[sh +: 2];
      endfunction

      function void note_request(input ast_req_type r);
         ast_rsp_type res;
         int          dec;
         int          idx;
         int          sh;
         logic [9:0]  base;
         logic [1:0]  c0, c1, f0, f1;
         logic [7:0]  b;
         res = '0;
         dec = r.decoder_address;
         cmd_seen[r.cmd]++;
         case (r.cmd)
            CMD_FEEDBACK_WRITE: begin
               if (dec < ACC_ADDRS) begin
                  decoder_marks[dec] = 1'b1;
                  if (dec < FB_TURNOUTS / 4 && dec < FB_BYTES) begin
                     res.old_byte        = reported_bytes[dec];
                     reported_bytes[dec] = r.feedback_data;
                  end else begin
                     res.old_byte       = decoder_bytes[dec];
                     decoder_bytes[dec] = r.feedback_data;
                  end
               end else begin
                  res.out_of_range = 1'b1;
               end
            end
            CMD_COIL_WRITE: begin
               idx = r.turnout_address[9:2];
               if (idx < ACC_ADDRS) begin
                  b  = decoder_bytes[idx];
                  sh = 2 * r.turnout_address[1:0];
                  b[sh +: 2] = r.coil ? POS_COIL1 : POS_COIL0;
                  decoder_bytes[idx] = b;
               end else begin
                  res.out_of_range = 1'b1;
               end
            end
            CMD_POSITION_READ: begin
               res.position = commanded_pos(r.turnout_address);
            end
            default: begin
               base = {r.decoder_address, r.half_select, 1'b0};
               c0   = commanded_pos(base);
               c1   = commanded_pos(base | 10'd1);
               f0   = reported_pos(base);
               f1   = reported_pos(base | 10'd1);
               res.reply_address = r.decoder_address;
               if (base < FB_TURNOUTS) begin
                  res.reply_info = (r.half_select ? TT_FEEDBACK_TURNOUT_HI : TT_FEEDBACK_TURNOUT)
                                   | {4'b0000, f1, f0};
                  if (c0 != f0 || c1 != f1) res.reply_info |= I_BIT;
               end else if (dec < ACC_ADDRS && decoder_marks[dec]) begin
                  b = decoder_bytes[dec];
                  res.reply_info = r.half_select ? (TT_FEEDBACK_DECODER_HI | {4'b0000, b[7:4]})
                                                 : (TT_FEEDBACK_DECODER | {4'b0000, b[3:0]});
               end else begin
                  res.reply_info = (r.half_select ? N_BIT : 8'h00) | {4'b0000, c1, c0};
               end
            end
         endcase
         flagged += res.out_of_range;
         owed_responses.push_back(res);
      endfunction

      function void check_response(input ast_rsp_type got);
         ast_rsp_type want;
         if (owed_responses.size() == 0) begin
            errors++;
            $display("%0t: unexpected response old=%h pos=%h addr=%h info=%h oor=%b",
                     $time, got.old_byte, got.position, got.reply_address,
                     got.reply_info, got.out_of_range);
            return;
         end
         want = owed_responses.pop_front();
         checked++;
         if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected old=%h pos=%h addr=%h info=%h oor=%b",
                     $time, want.old_byte, want.position, want.reply_address,
                     want.reply_info, want.out_of_range);
            $display("%0t:          actual   old=%h pos=%h addr=%h info=%h oor=%b",
                     $time, got.old_byte, got.position, got.reply_address,
                     got.reply_info, got.out_of_range);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ast_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ast_rsp_type rsp_data;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int cycle_count        = 0;
   int drain_pauses       = 0;

   status_table_scoreboard table_sb = new();

   accessory_status_table_top #(
      .ACCESSORY_ADDRESSES (ACC_ADDRS),
      .FEEDBACK_TURNOUTS   (FB_TURNOUTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Bound the run; a hung handshake ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d responses still owed",
                  $time, cycle_count, table_sb.pending());
         $display("accessory_status_table_top_tb: FAIL");
         $finish;
      end
   end

   // Response side: check on every accepted response, then pick the ready
   // level for the next cycle from the current stall rate
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) table_sb.check_response(rsp_data);
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   function automatic ast_req_type make_request(input logic [1:0] cmd,
                                                input logic [7:0] dec,
                                                input logic       half,
                                                input logic [9:0] turnout,
                                                input logic       coil,
                                                input logic [7:0] data);
      ast_req_type r;
      r.cmd             = cmd;
      r.decoder_address = dec;
      r.half_select     = half;
      r.turnout_address = turnout;
      r.coil            = coil;
      r.feedback_data   = data;
      return r;
   endfunction

   // Mostly addresses that land in or just past the stores, some from the
   // whole field so every bit toggles
   function automatic ast_req_type random_request();
      ast_req_type r;
      r.cmd             = 2'($urandom_range(3));
      r.decoder_address = ($urandom_range(99) < 70) ? 8'($urandom_range(35))
                                                     : 8'($urandom_range(255));
      r.half_select     = 1'($urandom_range(1));
      r.turnout_address = ($urandom_range(99) < 75) ? 10'($urandom_range(140))
                                                     : 10'($urandom_range(1023));
      r.coil            = 1'($urandom_range(1));
      r.feedback_data   = 8'($urandom_range(255));
      return r;
   endfunction

   // Present one request and hold it until accepted. Idle cycles come first,
   // so valid is only lowered in a step where it is not raised again.
   task automatic send_request(input ast_req_type r);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      table_sb.note_request(r);
   endtask

   // Hold the request side idle until every owed response is back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      drain_pauses++;
      do @(posedge clock); while (table_sb.pending() != 0);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
         if (i == PHASE_REQUESTS / 2) hold_until_drained();
         send_request(random_request());
      end
   endtask

   initial begin
      ast_req_type opening [$];

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Opening sequence: reset contents, mismatch bit set and cleared, the
      // feedback-turnout bytes at both ends, a feedback decoder's nibbles,
      // writes beyond both stores, plain turnouts and reads past the end.
      opening.push_back(make_request(CMD_INFO_READ,      8'd0,   1'b0, 10'd0,    1'b0, 8'h00));
      opening.push_back(make_request(CMD_COIL_WRITE,     8'd0,   1'b0, 10'd0,    1'b1, 8'h00));
      opening.push_back(make_request(CMD_INFO_READ,      8'd0,   1'b0, 10'd0,    1'b0, 8'h00));
      opening.push_back(make_request(CMD_FEEDBACK_WRITE, 8'd0,   1'b0, 10'd0,    1'b0, 8'h02));
      opening.push_back(make_request(CMD_INFO_READ,      8'd0,   1'b0, 10'd0,    1'b0, 8'h00));
      opening.push_back(make_request(CMD_FEEDBACK_WRITE, 8'd3,   1'b0, 10'd0,    1'b0, 8'hFF));
      opening.push_back(make_request(CMD_INFO_READ,      8'd3,   1'b1, 10'd0,    1'b0, 8'h00));
      opening.push_back(make_request(CMD_FEEDBACK_WRITE, 8'd4,   1'b0, 10'd0,    1'b0, 8'hA5));
      opening.push_back(make_request(CMD_FEEDBACK_WRITE, 8'd4,   1'b0, 10'd0,    1'b0, 8'h5A));
      opening.push_back(make_request(CMD_INFO_READ,      8'd4,   1'b0, 10'd0,    1'b0, 8'h00));
      opening.push_back(make_request(CMD_INFO_READ,      8'd4,   1'b1, 10'd0,    1'b0, 8'h00));
      opening.push_back(make_request(CMD_FEEDBACK_WRITE, 8'd31,  1'b0, 10'd0,    1'b0, 8'h00));
      opening.push_back(make_request(CMD_FEEDBACK_WRITE, 8'd32,  1'b0, 10'd0,    1'b0, 8'h11));
      opening.push_back(make_request(CMD_FEEDBACK_WRITE, 8'd255, 1'b1, 10'd1023, 1'b1, 8'hFF));
      opening.push_back(make_request(CMD_COIL_WRITE,     8'd0,   1'b0, 10'd127,  1'b0, 8'h00));
      opening.push_back(make_request(CMD_COIL_WRITE,     8'd0,   1'b0, 10'd128,  1'b1, 8'h00));
      opening.push_back(make_request(CMD_COIL_WRITE,     8'd0,   1'b0, 10'd1023, 1'b1, 8'h00));
      opening.push_back(make_request(CMD_COIL_WRITE,     8'd0,   1'b0, 10'd20,   1'b0, 8'h00));
      opening.push_back(make_request(CMD_COIL_WRITE,     8'd0,   1'b0, 10'd23,   1'b1, 8'h00));
      opening.push_back(make_request(CMD_POSITION_READ,  8'd0,   1'b0, 10'd20,   1'b0, 8'h00));
      opening.push_back(make_request(CMD_POSITION_READ,  8'd0,   1'b0, 10'd23,   1'b0, 8'h00));
      opening.push_back(make_request(CMD_POSITION_READ,  8'd0,   1'b0, 10'd1023, 1'b0, 8'h00));
      opening.push_back(make_request(CMD_POSITION_READ,  8'd0,   1'b0, 10'd127,  1'b0, 8'h00));
      opening.push_back(make_request(CMD_INFO_READ,      8'd5,   1'b0, 10'd0,    1'b0, 8'h00));
      opening.push_back(make_request(CMD_INFO_READ,      8'd5,   1'b1, 10'd0,    1'b0, 8'h00));
      opening.push_back(make_request(CMD_INFO_READ,      8'd255, 1'b1, 10'd0,    1'b0, 8'h00));
      foreach (opening[i]) send_request(opening[i]);

      // Random phases: free running, sparse requests, slow consumer, both
      run_phase(0, 0);
      run_phase(67, 0);
      run_phase(0, 67);
      run_phase(25, 25);

      // Drop valid, wait for the last responses, then allow a short tail
      // for any stray response
      req_valid <= 1'b0;
      do @(posedge clock); while (table_sb.pending() != 0);
      repeat (8) @(posedge clock);

      $display("Covered %0d requests: %0d feedback, %0d coil, %0d position, %0d info",
               table_sb.cmd_seen[CMD_FEEDBACK_WRITE] + table_sb.cmd_seen[CMD_COIL_WRITE]
               + table_sb.cmd_seen[CMD_POSITION_READ] + table_sb.cmd_seen[CMD_INFO_READ],
               table_sb.cmd_seen[CMD_FEEDBACK_WRITE], table_sb.cmd_seen[CMD_COIL_WRITE],
               table_sb.cmd_seen[CMD_POSITION_READ], table_sb.cmd_seen[CMD_INFO_READ]);
      $display("%0d checked, %0d flagged out of range, %0d drain pauses, %0d errors",
               table_sb.checked, table_sb.flagged, drain_pauses, table_sb.errors);
      if (table_sb.errors == 0 && table_sb.pending() == 0) begin
         $display("accessory_status_table_top_tb: PASS");
      end else begin
         $display("accessory_status_table_top_tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- accessory_status_table_top.f -----
design/ast_pkg.sv
design/accessory_status_table_top.sv
tb/accessory_status_table_top_tb.sv
